@@ rtl/core/bmphp_pkg.sv @@
// ----------------------------------------------------------------------------
// bmphp_pkg
// Shared types, constants and the header field map of the BMP byte parser.
// ----------------------------------------------------------------------------
package bmphp_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int OUT_DATA_W  = 88;

  localparam logic [5:0] RSV_FIRST   = 6'd6;
  localparam logic [5:0] RSV_LAST    = 6'd9;
  localparam logic [5:0] HEADER_LAST = 6'd53;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [3:0] FLD_SIGNATURE = 4'd0;
  localparam logic [3:0] FLD_SIZE      = 4'd1;
  localparam logic [3:0] FLD_OFFSET    = 4'd2;
  localparam logic [3:0] FLD_INFOSIZE  = 4'd3;
  localparam logic [3:0] FLD_WIDTH     = 4'd4;
  localparam logic [3:0] FLD_HEIGHT    = 4'd5;
  localparam logic [3:0] FLD_PLANES    = 4'd6;
  localparam logic [3:0] FLD_BITCOUNT  = 4'd7;
  localparam logic [3:0] FLD_COMPRESS  = 4'd8;
  localparam logic [3:0] FLD_SIZEIMAGE = 4'd9;
  localparam logic [3:0] FLD_XPELS     = 4'd10;
  localparam logic [3:0] FLD_YPELS     = 4'd11;
  localparam logic [3:0] FLD_CLRUSED   = 4'd12;
  localparam logic [3:0] FLD_CLRIMP    = 4'd13;

  typedef struct packed {
    logic       hit;
    logic [3:0] num;
    logic       half;
  } field_info_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  fnum;
    logic [31:0] fval;
    logic        dims;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] col;
    logic [11:0] row;
    logic        row_last;
    logic        img_last;
  } res_t;

  function automatic field_info_t field_info(input logic [5:0] pos);
    field_info_t fi;
    fi = '0;
    fi.hit = 1'b1;
    unique case (pos)
      6'd1:    begin fi.num = FLD_SIGNATURE; fi.half = 1'b1; end
      6'd5:    fi.num = FLD_SIZE;
      6'd13:   fi.num = FLD_OFFSET;
      6'd17:   fi.num = FLD_INFOSIZE;
      6'd21:   fi.num = FLD_WIDTH;
      6'd25:   fi.num = FLD_HEIGHT;
      6'd27:   begin fi.num = FLD_PLANES; fi.half = 1'b1; end
      6'd29:   begin fi.num = FLD_BITCOUNT; fi.half = 1'b1; end
      6'd33:   fi.num = FLD_COMPRESS;
      6'd37:   fi.num = FLD_SIZEIMAGE;
      6'd41:   fi.num = FLD_XPELS;
      6'd45:   fi.num = FLD_YPELS;
      6'd49:   fi.num = FLD_CLRUSED;
      6'd53:   fi.num = FLD_CLRIMP;
      default: fi.hit = 1'b0;
    endcase
    return fi;
  endfunction

endpackage

@@ rtl/core/bmp_header_and_pixel_parser_top.sv @@
// ----------------------------------------------------------------------------
// bmp_header_and_pixel_parser_top
// Streaming BMP reader: header fields and 24-bit pixels from a byte stream.
//
// channel | dir | tdata                          | tuser          | tlast
// in_     | in  | byte_value                     | start_of_file  | -
// out_    | out | field..row_last (see port)     | record_kind    | image_last
//
// One byte per cycle while in_tready is high; a byte passes through the input
// register, the parse logic and the result register before its result appears.
// Synchronous active-low reset returns the parser to header byte zero.
// A stalled output holds its result while the input register takes one more
// byte; in_tready drops only when both registers are full.
// ----------------------------------------------------------------------------
module bmp_header_and_pixel_parser_top #(
  parameter int MAX_DIM = bmphp_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // byte_value
  input  logic [0:0]                        in_tuser,   // start_of_file
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // field_number, field_value, dims_too_large, blue, green, red,
  // pixel_column, pixel_row, row_last, zero fill
  output logic [bmphp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [0:0]                        out_tuser,  // record_kind
  output logic                              out_tlast   // image_last
);

  logic            in_v_r, in_v_nxt;
  logic [7:0]      byte_r;
  logic            sof_r;
  logic            in_fire, s1_fire, adv;
  logic            res_vld;
  bmphp_pkg::res_t res, res_o;

  assign in_tready = !in_v_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = in_v_r && adv;
  assign in_v_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_tdata;
      sof_r  <= in_tuser[0];
    end
  end

  bmphp_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .byte_val (byte_r),
    .sof      (sof_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  bmphp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_fire && res_vld),
    .res_in    (res),
    .out_ready (out_tready),
    .adv       (adv),
    .out_valid (out_tvalid),
    .res_out   (res_o)
  );

  assign out_tdata = {2'b00, res_o.row_last, res_o.row, res_o.col, res_o.red,
                      res_o.green, res_o.blue, res_o.dims, res_o.fval, res_o.fnum};
  assign out_tuser = res_o.kind;
  assign out_tlast = res_o.img_last;

endmodule

@@ rtl/core/bmphp_parser.sv @@
// ----------------------------------------------------------------------------
// bmphp_parser
// Parse state and the single-pass next-state and result logic for one byte.
// ----------------------------------------------------------------------------
module bmphp_parser #(
  parameter int MAX_DIM = bmphp_pkg::MAX_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       byte_val,
  input  logic             sof,
  output logic             res_vld,
  output bmphp_pkg::res_t  res
);

  localparam int DIM_W = (MAX_DIM < 2) ? 2 : $clog2(MAX_DIM + 1);
  localparam logic [31:0] MAX_V = 32'(MAX_DIM);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PIXEL  = 2'd1;
  localparam logic [1:0] PH_PAD    = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  logic [1:0]       phase_r, phase_nxt, ph_c;
  logic [5:0]       pos_r, pos_nxt, pos_c;
  logic [31:0]      acc_r, acc_nxt, acc_c;
  logic [DIM_W-1:0] w_r, w_nxt, w_c;
  logic [DIM_W-1:0] h_r, h_nxt, h_c;
  logic             wbig_r, wbig_nxt, wbig_c;
  logic             wzero_r, wzero_nxt, wzero_c;
  logic             ok_r, ok_nxt, ok_c;
  logic [DIM_W-1:0] col_r, col_nxt, col_c;
  logic [DIM_W-1:0] row_r, row_nxt, row_c;
  logic [1:0]       comp_r, comp_nxt, comp_c;
  logic [1:0]       pad_r, pad_nxt, pad_c;
  logic [7:0]       hb_r, hb_nxt;
  logic [7:0]       hg_r, hg_nxt;

  bmphp_pkg::field_info_t fi;
  logic [31:0]      fv;
  logic             big;
  logic             rlast, ilast;
  logic [DIM_W:0]   col_p1, row_p1;
  logic [31:0]      col_x, row_x;

  always_comb begin
    ph_c    = sof ? PH_HEADER : phase_r;
    pos_c   = sof ? '0 : pos_r;
    acc_c   = sof ? '0 : acc_r;
    w_c     = sof ? '0 : w_r;
    h_c     = sof ? '0 : h_r;
    wbig_c  = sof ? 1'b0 : wbig_r;
    wzero_c = sof ? 1'b1 : wzero_r;
    ok_c    = sof ? 1'b0 : ok_r;
    col_c   = sof ? '0 : col_r;
    row_c   = sof ? '0 : row_r;
    comp_c  = sof ? '0 : comp_r;
    pad_c   = sof ? '0 : pad_r;

    phase_nxt = ph_c;
    pos_nxt   = pos_c;
    acc_nxt   = acc_c;
    w_nxt     = w_c;
    h_nxt     = h_c;
    wbig_nxt  = wbig_c;
    wzero_nxt = wzero_c;
    ok_nxt    = ok_c;
    col_nxt   = col_c;
    row_nxt   = row_c;
    comp_nxt  = comp_c;
    pad_nxt   = pad_c;
    hb_nxt    = sof ? '0 : hb_r;
    hg_nxt    = sof ? '0 : hg_r;

    res_vld = 1'b0;
    res     = '0;
    fi      = bmphp_pkg::field_info(pos_c);
    fv      = '0;
    big     = 1'b0;
    col_p1  = {1'b0, col_c} + (DIM_W+1)'(1);
    row_p1  = {1'b0, row_c} + (DIM_W+1)'(1);
    rlast   = col_p1 >= {1'b0, w_c};
    ilast   = rlast && (row_p1 >= {1'b0, h_c});
    col_x   = 32'(col_c);
    row_x   = 32'(row_c);

    unique case (ph_c)
      PH_HEADER: begin
        pos_nxt = pos_c + 6'd1;
        if (!(pos_c >= bmphp_pkg::RSV_FIRST && pos_c <= bmphp_pkg::RSV_LAST)) begin
          acc_nxt = {byte_val, acc_c[31:8]};
          if (pos_c >= bmphp_pkg::HEADER_LAST) begin
            phase_nxt = PH_IDLE;
          end
          if (fi.hit) begin
            fv = fi.half ? {16'b0, acc_nxt[31:16]} : acc_nxt;
            res_vld   = 1'b1;
            res.kind  = bmphp_pkg::KIND_HEADER;
            res.fnum  = fi.num;
            res.fval  = fv;
            acc_nxt   = '0;
            if (fi.num == bmphp_pkg::FLD_WIDTH) begin
              w_nxt     = fv[DIM_W-1:0];
              wbig_nxt  = fv > MAX_V;
              wzero_nxt = fv == 32'd0;
            end
            if (fi.num == bmphp_pkg::FLD_HEIGHT) begin
              h_nxt    = fv[DIM_W-1:0];
              big      = wbig_c || (fv > MAX_V);
              res.dims = big;
              ok_nxt   = !big && !wzero_c && (fv != 32'd0);
            end
            if (fi.num == bmphp_pkg::FLD_CLRIMP && ok_c) begin
              phase_nxt = PH_PIXEL;
            end
          end
        end
      end
      PH_PIXEL: begin
        case (comp_c)
          2'd0: begin
            hb_nxt   = byte_val;
            comp_nxt = 2'd1;
          end
          2'd1: begin
            hg_nxt   = byte_val;
            comp_nxt = 2'd2;
          end
          default: begin
            comp_nxt     = 2'd0;
            res_vld      = 1'b1;
            res.kind     = bmphp_pkg::KIND_PIXEL;
            res.blue     = hb_r;
            res.green    = hg_r;
            res.red      = byte_val;
            res.col      = col_x[11:0];
            res.row      = row_x[11:0];
            res.row_last = rlast;
            res.img_last = ilast;
            if (!rlast) begin
              col_nxt = col_c + DIM_W'(1);
            end else if (ilast) begin
              phase_nxt = PH_IDLE;
            end else begin
              col_nxt = '0;
              row_nxt = row_c + DIM_W'(1);
              pad_nxt = w_c[1:0];
              if (w_c[1:0] != 2'd0) begin
                phase_nxt = PH_PAD;
              end
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_nxt = pad_c - 2'd1;
        if (pad_c == 2'd1) begin
          phase_nxt = PH_PIXEL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      acc_r   <= '0;
      w_r     <= '0;
      h_r     <= '0;
      wbig_r  <= 1'b0;
      wzero_r <= 1'b1;
      ok_r    <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      comp_r  <= '0;
      pad_r   <= '0;
      hb_r    <= '0;
      hg_r    <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      wbig_r  <= wbig_nxt;
      wzero_r <= wzero_nxt;
      ok_r    <= ok_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      comp_r  <= comp_nxt;
      pad_r   <= pad_nxt;
      hb_r    <= hb_nxt;
      hg_r    <= hg_nxt;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXEL) |-> (col_r < w_r))
    else $error("column counter beyond image width");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAD) |-> (pad_r != 2'd0))
    else $error("padding phase with no padding left");

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    comp_r != 2'd3)
    else $error("component index out of range");

  a_img_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_vld && res.img_last) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after last pixel");

endmodule

@@ rtl/core/bmphp_out_reg.sv @@
// ----------------------------------------------------------------------------
// bmphp_out_reg
// Result register of the parser; frees itself in the cycle the result leaves.
// ----------------------------------------------------------------------------
module bmphp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  bmphp_pkg::res_t  res_in,
  input  logic             out_ready,
  output logic             adv,
  output logic             out_valid,
  output bmphp_pkg::res_t  res_out
);

  logic            vld_r, vld_nxt;
  bmphp_pkg::res_t res_r;

  assign adv     = !vld_r || out_ready;
  assign vld_nxt = adv ? load : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule
